// ===== hdl/pibd_pkg.sv =====
package pibd_pkg;

   // queue depths, used as defaults on the top level
   localparam int BYTE_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH  = 2;

   // field widths of the packed program format
   localparam logic [3:0] COUNT_BITS  = 4'd5;
   localparam logic [3:0] OPCODE_BITS = 4'd3;
   localparam logic [3:0] TYPE_BITS   = 4'd2;
   localparam logic [3:0] LABEL_BITS  = 4'd3;

   localparam logic KIND_INSTR = 1'b0;
   localparam logic KIND_LABEL = 1'b1;

   typedef struct packed {
      logic       record_kind;
      logic [2:0] opcode;
      logic [1:0] operand_count;
      logic [1:0] first_type;
      logic [7:0] first_value;
      logic [1:0] second_type;
      logic [7:0] second_value;
      logic [2:0] label_value;
      logic       last_of_run;
   } rsp_type;

   // status of a queue as seen by its neighbours
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hdl/pibd_fifo.sv =====
module pibd_fifo
   import pibd_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_data,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_data,
   output queue_status_type        status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] ptr);
      if (ptr == AW'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + AW'(1);
   endfunction

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full && !pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

// ===== hdl/pibd_back.sv =====
module pibd_back
   import pibd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       byte_data,
   output logic             byte_pop,
   input  logic             rsp_room,
   output logic             rsp_push,
   output rsp_type          rsp_data
);

   typedef enum logic [4:0] {
      PH_COUNT  = 5'b00001,
      PH_OPCODE = 5'b00010,
      PH_TYPE   = 5'b00100,
      PH_VALUE  = 5'b01000,
      PH_LABEL  = 5'b10000
   } phase_type;

   localparam logic [2:0] OP_CAL   = 3'b001;
   localparam logic [2:0] OP_RET   = 3'b010;
   localparam logic [2:0] OP_PRINT = 3'b101;
   localparam logic [2:0] OP_NOT   = 3'b110;
   localparam logic [2:0] OP_EQU   = 3'b111;

   localparam logic [1:0] TYPE_VALUE    = 2'd0;
   localparam logic [1:0] TYPE_REGISTER = 2'd1;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bits_left_ff, bits_left_in;
   logic [2:0]  bit_pos_ff, bit_pos_in;
   logic [7:0]  accum_ff, accum_in;
   logic [4:0]  instr_left_ff, instr_left_in;
   logic [1:0]  operands_left_ff, operands_left_in;
   logic [2:0]  held_opcode_ff, held_opcode_in;
   logic [1:0]  held_type_ff, held_type_in;
   logic [1:0]  held_first_type_ff, held_first_type_in;
   logic [7:0]  held_first_value_ff, held_first_value_in;
   logic [2:0]  bit_idx_ff;
   logic        pend_valid_ff, pend_valid_in;
   rsp_type     pend_ff, pend_in;

   logic        step;
   logic        byte_end;
   logic        cur_bit;
   logic [7:0]  accum_next;
   logic        field_done;
   logic        new_res;
   rsp_type     res;
   logic [4:0]  instr_dec;
   logic [1:0]  op_total;
   logic [1:0]  held_total;
   logic        flush;
   logic        push_old;

   function automatic logic [1:0] operand_total(input logic [2:0] op);
      case (op)
         OP_RET:                             return 2'd0;
         OP_CAL, OP_PRINT, OP_NOT, OP_EQU:   return 2'd1;
         default:                            return 2'd2;
      endcase
   endfunction

   function automatic logic [3:0] value_width(input logic [1:0] t);
      case (t)
         TYPE_VALUE:    return 4'd8;
         TYPE_REGISTER: return 4'd3;
         default:       return 4'd5;
      endcase
   endfunction

   assign step       = byte_valid && rsp_room;
   assign byte_end   = (bit_idx_ff == 3'd7);
   assign byte_pop   = step && byte_end;
   assign cur_bit    = byte_data[bit_idx_ff];
   assign accum_next = accum_ff | ({7'd0, cur_bit} << bit_pos_ff);
   assign field_done = (bits_left_ff == 4'd1);
   assign instr_dec  = (instr_left_ff != 5'd0) ? instr_left_ff - 5'd1 : instr_left_ff;
   assign op_total   = operand_total(accum_next[2:0]);
   assign held_total = operand_total(held_opcode_ff);

   // one bit of the field in flight per step
   always_comb begin
      phase_in            = phase_ff;
      bits_left_in        = bits_left_ff - 4'd1;
      bit_pos_in          = bit_pos_ff + 3'd1;
      accum_in            = accum_next;
      instr_left_in       = instr_left_ff;
      operands_left_in    = operands_left_ff;
      held_opcode_in      = held_opcode_ff;
      held_type_in        = held_type_ff;
      held_first_type_in  = held_first_type_ff;
      held_first_value_in = held_first_value_ff;
      new_res             = 1'b0;
      res                 = '0;

      if (field_done) begin
         accum_in   = '0;
         bit_pos_in = '0;
         case (phase_ff)
            PH_OPCODE: begin
               held_opcode_in   = accum_next[2:0];
               operands_left_in = op_total;
               if (op_total == 2'd0) begin
                  new_res          = 1'b1;
                  res.record_kind  = KIND_INSTR;
                  res.opcode       = accum_next[2:0];
                  instr_left_in    = instr_dec;
                  phase_in         = (instr_dec == 5'd0) ? PH_LABEL : PH_OPCODE;
                  bits_left_in     = (instr_dec == 5'd0) ? LABEL_BITS : OPCODE_BITS;
               end else begin
                  phase_in     = PH_TYPE;
                  bits_left_in = TYPE_BITS;
               end
            end
            PH_TYPE: begin
               held_type_in = accum_next[1:0];
               phase_in     = PH_VALUE;
               bits_left_in = value_width(accum_next[1:0]);
            end
            PH_VALUE: begin
               if (held_total == 2'd2 && operands_left_ff == 2'd2) begin
                  held_first_type_in  = held_type_ff;
                  held_first_value_in = accum_next;
                  operands_left_in    = 2'd1;
                  phase_in            = PH_TYPE;
                  bits_left_in        = TYPE_BITS;
               end else begin
                  operands_left_in = 2'd0;
                  new_res          = 1'b1;
                  res.record_kind  = KIND_INSTR;
                  res.opcode       = held_opcode_ff;
                  if (held_total == 2'd2) begin
                     res.operand_count = 2'd2;
                     res.first_type    = held_first_type_ff;
                     res.first_value   = held_first_value_ff;
                     res.second_type   = held_type_ff;
                     res.second_value  = accum_next;
                  end else begin
                     res.operand_count = 2'd1;
                     res.first_type    = held_type_ff;
                     res.first_value   = accum_next;
                  end
                  instr_left_in = instr_dec;
                  phase_in      = (instr_dec == 5'd0) ? PH_LABEL : PH_OPCODE;
                  bits_left_in  = (instr_dec == 5'd0) ? LABEL_BITS : OPCODE_BITS;
               end
            end
            PH_LABEL: begin
               new_res         = 1'b1;
               res.record_kind = KIND_LABEL;
               res.label_value = accum_next[2:0];
               phase_in        = PH_COUNT;
               bits_left_in    = COUNT_BITS;
            end
            default: begin
               // instruction count; zero runs one instruction
               instr_left_in = (accum_next[4:0] == 5'd0) ? 5'd1 : accum_next[4:0];
               phase_in      = PH_OPCODE;
               bits_left_in  = OPCODE_BITS;
            end
         endcase
      end
   end

   // results wait one behind so the last one of each byte can be marked;
   // items end at least three bits apart, so only one push per cycle
   assign flush    = pend_valid_ff && pend_ff.last_of_run && rsp_room;
   assign push_old = step && pend_valid_ff && !pend_ff.last_of_run && (new_res || byte_end);
   assign rsp_push = flush || push_old;

   always_comb begin
      rsp_data             = pend_ff;
      rsp_data.last_of_run = pend_ff.last_of_run || (step && byte_end && !new_res);
   end

   always_comb begin
      pend_in       = res;
      pend_in.last_of_run = byte_end;
      pend_valid_in = pend_valid_ff;
      if (step && new_res) begin
         pend_valid_in = 1'b1;
      end else if (rsp_push) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff            <= PH_COUNT;
         bits_left_ff        <= COUNT_BITS;
         bit_pos_ff          <= '0;
         accum_ff            <= '0;
         instr_left_ff       <= '0;
         operands_left_ff    <= '0;
         held_opcode_ff      <= '0;
         held_type_ff        <= '0;
         held_first_type_ff  <= '0;
         held_first_value_ff <= '0;
         bit_idx_ff          <= '0;
         pend_valid_ff       <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         if (step) begin
            phase_ff            <= phase_in;
            bits_left_ff        <= bits_left_in;
            bit_pos_ff          <= bit_pos_in;
            accum_ff            <= accum_in;
            instr_left_ff       <= instr_left_in;
            operands_left_ff    <= operands_left_in;
            held_opcode_ff      <= held_opcode_in;
            held_type_ff        <= held_type_in;
            held_first_type_ff  <= held_first_type_in;
            held_first_value_ff <= held_first_value_in;
            bit_idx_ff          <= bit_idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step && new_res) begin
         pend_ff <= pend_in;
      end
   end

`ifndef ASSERT_OFF
   a_field_length: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff != 4'd0 && bits_left_ff <= 4'd8)
      else $error("field length out of range");

   a_single_push: assert property (@(posedge clock) disable iff (reset)
      (step && new_res && pend_valid_ff) |-> !pend_ff.last_of_run)
      else $error("two results due in one cycle");

   a_flush_once: assert property (@(posedge clock) disable iff (reset)
      flush |=> !(pend_valid_ff && pend_ff.last_of_run))
      else $error("closing result of a byte not released");
`endif

endmodule

// ===== hdl/packed_instruction_bit_decoder_core.sv =====
// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_ready  | req_in_byte
// rsp      | out       | rsp_valid/rsp_ready  | rsp_record_kind .. rsp_last_of_run
//
// each byte is decoded bit-serially, one bit per cycle while the result queue has room;
// a result moves on when the next item or the byte ends; if on bit seven, once there is room.
// bytes wait in a short queue ahead of the decoder, results in a queue behind it.
// synchronous active-high reset empties both queues and restarts at an instruction count.
// the decoder holds whenever the result queue is full; input stalls once the byte queue fills.
module packed_instruction_bit_decoder_core
   import pibd_pkg::*;
#(
   parameter int BYTE_DEPTH = BYTE_QUEUE_DEPTH,
   parameter int RSP_DEPTH  = RSP_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_record_kind,
   output logic [2:0] rsp_opcode,
   output logic [1:0] rsp_operand_count,
   output logic [1:0] rsp_first_type,
   output logic [7:0] rsp_first_value,
   output logic [1:0] rsp_second_type,
   output logic [7:0] rsp_second_value,
   output logic [2:0] rsp_label_value,
   output logic       rsp_last_of_run
);

   localparam int RSP_WIDTH = $bits(rsp_type);

   queue_status_type       byte_status;
   queue_status_type       rsp_status;
   logic [7:0]             byte_head;
   logic                   byte_pop;
   logic                   dec_push;
   rsp_type                dec_data;
   logic [RSP_WIDTH-1:0]   rsp_head_bits;
   rsp_type                rsp_head;

   assign req_ready = !byte_status.full;

   pibd_fifo #(
      .WIDTH(8),
      .DEPTH(BYTE_DEPTH)
   ) u_byte_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && req_ready),
      .push_data (req_in_byte),
      .pop       (byte_pop),
      .pop_data  (byte_head),
      .status    (byte_status)
   );

   pibd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (!byte_status.empty),
      .byte_data  (byte_head),
      .byte_pop   (byte_pop),
      .rsp_room   (!rsp_status.full),
      .rsp_push   (dec_push),
      .rsp_data   (dec_data)
   );

   pibd_fifo #(
      .WIDTH(RSP_WIDTH),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (dec_push),
      .push_data (dec_data),
      .pop       (rsp_valid && rsp_ready),
      .pop_data  (rsp_head_bits),
      .status    (rsp_status)
   );

   assign rsp_head          = rsp_type'(rsp_head_bits);
   assign rsp_valid         = !rsp_status.empty;
   assign rsp_record_kind   = rsp_head.record_kind;
   assign rsp_opcode        = rsp_head.opcode;
   assign rsp_operand_count = rsp_head.operand_count;
   assign rsp_first_type    = rsp_head.first_type;
   assign rsp_first_value   = rsp_head.first_value;
   assign rsp_second_type   = rsp_head.second_type;
   assign rsp_second_value  = rsp_head.second_value;
   assign rsp_label_value   = rsp_head.label_value;
   assign rsp_last_of_run   = rsp_head.last_of_run;

endmodule
